// ===== hw/rtl/adcp_pkg.sv =====
package adcp_pkg;

  localparam int CodeW        = 6;
  localparam int CodesPerWord = 10;
  localparam int WordW        = CodeW * CodesPerWord;
  localparam int PendW        = CodeW * (CodesPerWord - 1);
  localparam int CountW       = 4;
  localparam int CharW        = 8;
  localparam int AsciiW       = 7;
  localparam int RomW         = 8;
  localparam int QDepth       = 3;

  localparam logic [CodeW-1:0]  EscLow  = 6'o74;
  localparam logic [CodeW-1:0]  EscHigh = 6'o76;
  localparam logic [AsciiW-1:0] ChCr    = 7'o15;
  localparam logic [AsciiW-1:0] ChLf    = 7'o12;

  // Entry codes: 000-077 single code, 0100-0177 escape 74 plus the low six
  // bits, 0200-0277 escape 76 plus the low six bits.
  localparam logic [RomW-1:0] DisplayRom [0:127] = '{
    8'o240, 8'o241, 8'o242, 8'o243, 8'o244, 8'o245, 8'o246, 8'o247,
    8'o250, 8'o251, 8'o252, 8'o253, 8'o254, 8'o255, 8'o256, 8'o257,
    8'o260, 8'o261, 8'o262, 8'o263, 8'o264, 8'o265, 8'o266, 8'o267,
    8'o270, 8'o271, 8'o272, 8'o273, 8'o274, 8'o275, 8'o276, 8'o277,
    8'o055, 8'o066, 8'o064, 8'o060, 8'o053, 8'o063, 8'o067, 8'o070,
    8'o051, 8'o052, 8'o047, 8'o045, 8'o056, 8'o046, 8'o057, 8'o050,
    8'o033, 8'o034, 8'o035, 8'o036, 8'o037, 8'o040, 8'o041, 8'o042,
    8'o043, 8'o044, 8'o104, 8'o077, 8'o072, 8'o054, 8'o073, 8'o071,
    8'o101, 8'o001, 8'o002, 8'o003, 8'o004, 8'o005, 8'o006, 8'o007,
    8'o010, 8'o011, 8'o012, 8'o013, 8'o014, 8'o015, 8'o016, 8'o017,
    8'o020, 8'o021, 8'o022, 8'o023, 8'o024, 8'o025, 8'o026, 8'o027,
    8'o030, 8'o031, 8'o032, 8'o061, 8'o075, 8'o062, 8'o104, 8'o065,
    8'o107, 8'o201, 8'o202, 8'o203, 8'o204, 8'o205, 8'o206, 8'o207,
    8'o210, 8'o211, 8'o212, 8'o213, 8'o214, 8'o215, 8'o216, 8'o217,
    8'o220, 8'o221, 8'o222, 8'o223, 8'o224, 8'o225, 8'o226, 8'o227,
    8'o230, 8'o231, 8'o232, 8'o233, 8'o234, 8'o235, 8'o236, 8'o237
  };

endpackage

// ===== hw/rtl/adcp_in_if.sv =====
interface adcp_in_if;
  import adcp_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [CharW-1:0] char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink   (input valid, input action, input char_code, output ready);
endinterface

// ===== hw/rtl/adcp_out_if.sv =====
interface adcp_out_if;
  import adcp_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] word;
  logic             last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

// ===== hw/rtl/ascii_to_display_code_packer_unit.sv =====
// Channel  Dir  Payload                        Item
// chars    in   action[0], char_code[7:0]      one byte or end-of-line mark
// words    out  word[59:0], last[0]            one packed word of ten codes
//
// One item is taken per cycle while the input is ready; its words reach
// the output register queue at the next edge and are shown one per cycle
// from the head of the queue while the output is ready. An end of line
// with nine codes held makes two words. The input is ready while the queue
// holds at most one word and reset is low. Reset clears the held codes and
// empties the queue.
module ascii_to_display_code_packer_unit
  import adcp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  adcp_in_if.sink    chars,
  adcp_out_if.source words
);

  logic [PendW-1:0]  pending;
  logic [CountW-1:0] count;
  logic [PendW-1:0]  pending_next;
  logic [CountW-1:0] count_next;

  logic [WordW-1:0] q_word [QDepth];
  logic             q_last [QDepth];
  logic [1:0]       q_count;
  logic [WordW-1:0] q_word_next [QDepth];
  logic             q_last_next [QDepth];
  logic [1:0]       q_count_next;

  logic [AsciiW-1:0]      ch;
  logic                   eol;
  logic                   crlf;
  logic [RomW-1:0]        rom_val;
  logic                   has_esc;
  logic [CodeW-1:0]       c0;
  logic [CodeW-1:0]       c1;
  logic [PendW+2*CodeW-1:0] full;
  logic                   cnt_sat;
  logic [5:0]             pad_shift;

  logic [1:0]       n_res;
  logic [WordW-1:0] res0_word;
  logic             res0_last;
  logic [WordW-1:0] res1_word;

  logic       accept;
  logic       pop;
  logic [1:0] base;

  assign accept       = chars.valid & chars.ready;
  assign pop          = words.valid & words.ready;
  assign chars.ready  = !rst && (q_count <= 2'd1);
  assign words.valid  = (q_count != 2'd0);
  assign words.word   = q_word[0];
  assign words.last   = q_last[0];

  assign ch      = chars.char_code[AsciiW-1:0];
  assign eol     = chars.action | (ch == '0);
  assign crlf    = (ch == ChCr) || (ch == ChLf);
  assign rom_val = DisplayRom[ch];
  assign has_esc = |rom_val[7:6];
  assign c1      = rom_val[CodeW-1:0];
  assign c0      = has_esc ? (rom_val[7] ? EscHigh : EscLow) : c1;
  assign full    = has_esc ? {pending, c0, c1} : {{CodeW{1'b0}}, pending, c0};
  // A count of nine or more means the next code closes the word.
  assign cnt_sat = (count >= 4'd9);
  assign pad_shift = 6'(({2'b00, 4'd9 - count}) * 6'd6);

  always_comb begin
    pending_next = pending;
    count_next   = count;
    n_res        = 2'd0;
    res0_word    = '0;
    res0_last    = 1'b1;
    res1_word    = '0;
    if (eol) begin
      pending_next = '0;
      count_next   = '0;
      if (count == '0) begin
        n_res = 2'd1;
      end else if (cnt_sat) begin
        // The padded word has only one zero code, so a zero word follows.
        n_res     = 2'd2;
        res0_word = {pending, {CodeW{1'b0}}};
        res0_last = 1'b0;
      end else begin
        n_res     = 2'd1;
        res0_word = {pending, {CodeW{1'b0}}} << pad_shift;
      end
    end else if (!crlf) begin
      if (has_esc) begin
        if (count == 4'd8) begin
          n_res        = 2'd1;
          res0_word    = full[WordW-1:0];
          pending_next = '0;
          count_next   = '0;
        end else if (cnt_sat) begin
          // The escape closes the word and its code opens the next one.
          n_res        = 2'd1;
          res0_word    = {pending, c0};
          pending_next = {{(PendW-CodeW){1'b0}}, c1};
          count_next   = 4'd1;
        end else begin
          pending_next = full[PendW-1:0];
          count_next   = count + 4'd2;
        end
      end else begin
        if (cnt_sat) begin
          n_res        = 2'd1;
          res0_word    = {pending, c0};
          pending_next = '0;
          count_next   = '0;
        end else begin
          pending_next = full[PendW-1:0];
          count_next   = count + 4'd1;
        end
      end
    end
  end

  assign base = q_count - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      q_word_next[i] = q_word[i];
      q_last_next[i] = q_last[i];
      if (pop && (i < QDepth - 1)) begin
        q_word_next[i] = q_word[(i + 1) % QDepth];
        q_last_next[i] = q_last[(i + 1) % QDepth];
      end
      if (accept && (n_res != 2'd0) && (base == 2'(i))) begin
        q_word_next[i] = res0_word;
        q_last_next[i] = res0_last;
      end
      if (accept && (n_res == 2'd2) && (base + 2'd1 == 2'(i))) begin
        q_word_next[i] = res1_word;
        q_last_next[i] = 1'b1;
      end
    end
    q_count_next = base + (accept ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      count   <= '0;
      q_count <= '0;
    end else begin
      if (accept) begin
        pending <= pending_next;
        count   <= count_next;
      end
      q_count <= q_count_next;
    end
    for (int i = 0; i < QDepth; i++) begin
      q_word[i] <= q_word_next[i];
      q_last[i] <= q_last_next[i];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 4'd9)
    else $error("held code count beyond nine");

  a_queue_range: assert property (@(posedge clk) disable iff (rst)
    q_count <= 2'd3)
    else $error("output queue overfilled");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    accept && eol |=> (count == '0) && (pending == '0))
    else $error("end of line left codes held");

  a_two_words: assert property (@(posedge clk) disable iff (rst)
    accept && eol && (count == 4'd9) |=> q_count >= 2'd2)
    else $error("full end of line did not queue two words");

endmodule
